>>> hdl/svpwm_sector_and_duty_defines.svh
// Assertion macros shared by the checker files of the SVPWM block.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef SVPWM_SECTOR_AND_DUTY_DEFINES_SVH
`define SVPWM_SECTOR_AND_DUTY_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define SVSD_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define SVSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SVSD_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/svsd_pkg.sv
`default_nettype none

package svsd_pkg;

   // Field widths.
   localparam int unsigned VOLT_W      = 16;
   localparam int unsigned TICK_W      = 16;
   localparam int unsigned GAIN_W      = 32;
   localparam int unsigned SECTOR_W    = 3;
   localparam int unsigned MAG_W       = 32;

   // Configuration port.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_PERIOD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_TIME_GAIN     = 1'b1;

   // Default depth of the queue between front and back.
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   // sqrt(3)/2 in Q16.
   localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;

   // One classified vector: sector and the two active-term magnitudes.
   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [MAG_W-1:0]    mag_a;
      logic [MAG_W-1:0]    mag_b;
   } svsd_item_type;

   // Sector from the negative flags of u3, u2 and u1 (msb to lsb).
   function automatic logic [SECTOR_W-1:0] sector_of_signs(input logic [2:0] signs);
      logic [SECTOR_W-1:0] sec;
      case (signs)
         3'd1:    sec = 3'd5;
         3'd2:    sec = 3'd3;
         3'd3:    sec = 3'd4;
         3'd4:    sec = 3'd1;
         3'd5:    sec = 3'd6;
         3'd6:    sec = 3'd2;
         default: sec = 3'd0;
      endcase
      return sec;
   endfunction

endpackage

`default_nettype wire

>>> hdl/svsd_ifs.sv
`default_nettype none

// Input channel: one alpha/beta voltage vector per beat.
interface svsd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [svsd_pkg::VOLT_W-1:0]  v_alpha;
   logic signed [svsd_pkg::VOLT_W-1:0]  v_beta;

   modport source (output valid, output v_alpha, output v_beta, input ready);
   modport sink   (input valid, input v_alpha, input v_beta, output ready);
endinterface

// Result channel: three phase compares and the sector per beat.
interface svsd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [svsd_pkg::TICK_W-1:0]     compare_u;
   logic [svsd_pkg::TICK_W-1:0]     compare_v;
   logic [svsd_pkg::TICK_W-1:0]     compare_w;
   logic [svsd_pkg::SECTOR_W-1:0]   sector_number;

   modport source (output valid, output compare_u, output compare_v, output compare_w,
                   output sector_number, input ready);
   modport sink   (input valid, input compare_u, input compare_v, input compare_w,
                   input sector_number, output ready);
endinterface

`default_nettype wire

>>> hdl/svsd_front.sv
`default_nettype none

module svsd_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   svsd_req_if.sink                     req_ch,
   output logic                         push,
   output svsd_pkg::svsd_item_type      push_item,
   input  wire logic                    q_full
);
   import svsd_pkg::*;

   logic                    adv;
   logic signed [17:0]      k_sqrt3;
   logic signed [33:0]      prod_in;

   logic                    f1_vld_ff;
   logic                    f1_vld_in;
   logic signed [VOLT_W-1:0] f1_b_ff;
   logic signed [VOLT_W-1:0] f1_b_in;
   logic signed [33:0]      f1_pa_ff;
   logic signed [33:0]      f1_pa_in;

   logic signed [33:0]      u0;
   logic signed [33:0]      u1;
   logic signed [33:0]      u2;
   logic signed [33:0]      b_half;
   logic signed [33:0]      n0;
   logic signed [33:0]      n1;
   logic signed [33:0]      n2;
   logic [MAG_W-1:0]        m0;
   logic [MAG_W-1:0]        m1;
   logic [MAG_W-1:0]        m2;
   logic [SECTOR_W-1:0]     sec;

   logic                    f2_vld_ff;
   logic                    f2_vld_in;
   svsd_item_type           f2_item_ff;
   svsd_item_type           f2_item_in;

   // The front moves whenever its last stage is empty or can drain into the queue.
   assign adv          = !f2_vld_ff || !q_full;
   assign req_ch.ready = adv;
   assign push         = f2_vld_ff && !q_full;
   assign push_item    = f2_item_ff;

   // Stage 1: scale alpha by sqrt(3)/2.
   assign k_sqrt3   = $signed({1'b0, SQRT3_HALF_Q16});
   assign prod_in   = 34'(req_ch.v_alpha) * 34'(k_sqrt3);
   assign f1_vld_in = req_ch.valid;
   assign f1_b_in   = req_ch.v_beta;
   assign f1_pa_in  = prod_in;

   // Stage 2: form the three terms, find the sector and pick the active magnitudes.
   always_comb begin
      b_half = 34'($signed({f1_b_ff, 15'h0}));
      u0     = 34'($signed({f1_b_ff, 16'h0}));
      u1     = f1_pa_ff - b_half;
      u2     = -f1_pa_ff - b_half;
      n0     = -u0;
      n1     = -u1;
      n2     = -u2;
      m0     = u0[33] ? n0[MAG_W-1:0] : u0[MAG_W-1:0];
      m1     = u1[33] ? n1[MAG_W-1:0] : u1[MAG_W-1:0];
      m2     = u2[33] ? n2[MAG_W-1:0] : u2[MAG_W-1:0];
      sec    = sector_of_signs({u2[33], u1[33], u0[33]});

      f2_item_in.sector = sec;
      case (sec)
         3'd1: begin
            f2_item_in.mag_a = m1;
            f2_item_in.mag_b = m0;
         end
         3'd2: begin
            f2_item_in.mag_a = m1;
            f2_item_in.mag_b = m2;
         end
         3'd3: begin
            f2_item_in.mag_a = m0;
            f2_item_in.mag_b = m2;
         end
         3'd4: begin
            f2_item_in.mag_a = m0;
            f2_item_in.mag_b = m1;
         end
         3'd5: begin
            f2_item_in.mag_a = m2;
            f2_item_in.mag_b = m1;
         end
         3'd6: begin
            f2_item_in.mag_a = m2;
            f2_item_in.mag_b = m0;
         end
         default: begin
            f2_item_in.mag_a = '0;
            f2_item_in.mag_b = '0;
         end
      endcase
   end

   assign f2_vld_in = f1_vld_ff;

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff <= f1_vld_in;
         f2_vld_ff <= f2_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         f1_b_ff    <= f1_b_in;
         f1_pa_ff   <= f1_pa_in;
         f2_item_ff <= f2_item_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/svsd_queue.sv
`default_nettype none

module svsd_queue #(
   parameter int unsigned DEPTH = svsd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  svsd_pkg::svsd_item_type      push_item,
   output logic                         full,
   input  wire logic                    pop,
   output svsd_pkg::svsd_item_type      pop_item,
   output logic                         empty
);
   import svsd_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   svsd_item_type       mem [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_item = mem[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> hdl/svsd_back.sv
`default_nettype none

module svsd_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  svsd_pkg::svsd_item_type          pop_item,
   input  wire logic                        q_empty,
   output logic                             pop,
   input  wire logic [svsd_pkg::TICK_W-1:0] active_period,
   input  wire logic [svsd_pkg::GAIN_W-1:0] time_gain,
   svsd_rsp_if.source                       rsp_ch
);
   import svsd_pkg::*;

   localparam int unsigned T_W   = 48;   // vector time in Q16 ticks
   localparam int unsigned ACC_W = 51;   // signed compare sums in Q17

   logic                    adv;

   logic [63:0]             prod_a;
   logic [63:0]             prod_b;
   logic                    b1_vld_ff;
   logic [SECTOR_W-1:0]     b1_sec_ff;
   logic [T_W-1:0]          b1_ta_ff;
   logic [T_W-1:0]          b1_ta_in;
   logic [T_W-1:0]          b1_tb_ff;
   logic [T_W-1:0]          b1_tb_in;

   logic signed [ACC_W-1:0] ts_w;
   logic signed [ACC_W-1:0] ta_w;
   logic signed [ACC_W-1:0] tb_w;
   logic                    b2_vld_ff;
   logic [SECTOR_W-1:0]     b2_sec_ff;
   logic signed [ACC_W-1:0] b2_all_ff;
   logic signed [ACC_W-1:0] b2_all_in;
   logic signed [ACC_W-1:0] b2_mid_ff;
   logic signed [ACC_W-1:0] b2_mid_in;
   logic signed [ACC_W-1:0] b2_none_ff;
   logic signed [ACC_W-1:0] b2_none_in;

   logic [TICK_W-1:0]       c_all;
   logic [TICK_W-1:0]       c_mid;
   logic [TICK_W-1:0]       c_none;
   logic                    out_vld_ff;
   logic [TICK_W-1:0]       cmp_u_ff;
   logic [TICK_W-1:0]       cmp_u_in;
   logic [TICK_W-1:0]       cmp_v_ff;
   logic [TICK_W-1:0]       cmp_v_in;
   logic [TICK_W-1:0]       cmp_w_ff;
   logic [TICK_W-1:0]       cmp_w_in;
   logic [SECTOR_W-1:0]     sec_out_ff;

   // Q17 value to ticks: negative gives zero, large values saturate at the period.
   function automatic logic [TICK_W-1:0] to_ticks(input logic signed [ACC_W-1:0] v,
                                                   input logic [TICK_W-1:0] per);
      logic [ACC_W-19:0] t;
      logic [TICK_W-1:0] r;
      t = v[ACC_W-2:17];
      if (v[ACC_W-1]) begin
         r = '0;
      end else if (t > (ACC_W - 18)'(per)) begin
         r = per;
      end else begin
         r = t[TICK_W-1:0];
      end
      return r;
   endfunction

   // The whole back end stalls together when the output beat is held.
   assign adv = !out_vld_ff || rsp_ch.ready;
   assign pop = adv && !q_empty;

   // Stage 1: active vector times.
   assign prod_a   = {32'h0, pop_item.mag_a} * {32'h0, time_gain};
   assign prod_b   = {32'h0, pop_item.mag_b} * {32'h0, time_gain};
   assign b1_ta_in = prod_a[63:16];
   assign b1_tb_in = prod_b[63:16];

   // Stage 2: compare sums around the zero time.
   always_comb begin
      ts_w       = $signed(ACC_W'({active_period, 16'h0}));
      ta_w       = $signed(ACC_W'(b1_ta_ff));
      tb_w       = $signed(ACC_W'(b1_tb_ff));
      b2_all_in  = ts_w - ta_w - tb_w;
      b2_mid_in  = ts_w + ta_w - tb_w;
      b2_none_in = ts_w + ta_w + tb_w;
   end

   // Stage 3: clamp and route the compares to the phases of this sector.
   always_comb begin
      c_all  = to_ticks(b2_all_ff, active_period);
      c_mid  = to_ticks(b2_mid_ff, active_period);
      c_none = to_ticks(b2_none_ff, active_period);
      case (b2_sec_ff)
         3'd1: begin
            cmp_u_in = c_all;
            cmp_v_in = c_mid;
            cmp_w_in = c_none;
         end
         3'd2: begin
            cmp_u_in = c_mid;
            cmp_v_in = c_all;
            cmp_w_in = c_none;
         end
         3'd3: begin
            cmp_u_in = c_none;
            cmp_v_in = c_all;
            cmp_w_in = c_mid;
         end
         3'd4: begin
            cmp_u_in = c_none;
            cmp_v_in = c_mid;
            cmp_w_in = c_all;
         end
         3'd5: begin
            cmp_u_in = c_mid;
            cmp_v_in = c_none;
            cmp_w_in = c_all;
         end
         3'd6: begin
            cmp_u_in = c_all;
            cmp_v_in = c_none;
            cmp_w_in = c_mid;
         end
         default: begin
            cmp_u_in = '0;
            cmp_v_in = '0;
            cmp_w_in = '0;
         end
      endcase
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff  <= 1'b0;
         b2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         b1_vld_ff  <= pop;
         b2_vld_ff  <= b1_vld_ff;
         out_vld_ff <= b2_vld_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         b1_sec_ff  <= pop_item.sector;
         b1_ta_ff   <= b1_ta_in;
         b1_tb_ff   <= b1_tb_in;
         b2_sec_ff  <= b1_sec_ff;
         b2_all_ff  <= b2_all_in;
         b2_mid_ff  <= b2_mid_in;
         b2_none_ff <= b2_none_in;
         cmp_u_ff   <= cmp_u_in;
         cmp_v_ff   <= cmp_v_in;
         cmp_w_ff   <= cmp_w_in;
         sec_out_ff <= b2_sec_ff;
      end
   end

   assign rsp_ch.valid         = out_vld_ff;
   assign rsp_ch.compare_u     = cmp_u_ff;
   assign rsp_ch.compare_v     = cmp_v_ff;
   assign rsp_ch.compare_w     = cmp_w_ff;
   assign rsp_ch.sector_number = sec_out_ff;

endmodule

`default_nettype wire

>>> hdl/svpwm_sector_and_duty.sv
// Seven-segment space vector PWM: sector and center-aligned phase compares.
// req_ch carries one alpha/beta voltage vector per beat (valid/ready).
// rsp_ch returns, per vector, the U, V and W timer compares and the sector
// (1 to 6, or 0 with all compares 0 when the vector has no sector).
// The csr_ port writes active_period (index 0) and time_gain (index 1, Q16.16);
// write them only while no vector is in flight.
// Path of a vector: 2 front stages, one queue slot, 3 back stages with two
// 32x32 multipliers. Throughput: one vector per cycle while rsp_ch.ready
// stays high, set by the pipelined front and back.
// When the receiver holds rsp_ch.ready low the back end freezes with its
// beat on the output; the front keeps taking vectors until the QUEUE_DEPTH
// queue entries and the last front stage are all full, then req_ch.ready drops.
// Synchronous reset empties both pipelines and the queue and clears both
// registers to 0.
`default_nettype none

module svpwm_sector_and_duty #(
   parameter int unsigned QUEUE_DEPTH = svsd_pkg::QUEUE_DEPTH_DEF   // at least 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   svsd_req_if.sink                                  req_ch,
   svsd_rsp_if.source                                rsp_ch,
   input  wire logic                                 csr_wr_en,
   input  wire logic [svsd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [svsd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import svsd_pkg::*;

   logic [TICK_W-1:0]   period_ff;
   logic [GAIN_W-1:0]   gain_ff;

   logic                push;
   svsd_item_type       push_item;
   logic                q_full;
   logic                pop;
   svsd_item_type       pop_item;
   logic                q_empty;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         gain_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ACTIVE_PERIOD: period_ff <= csr_wdata[TICK_W-1:0];
            REG_TIME_GAIN:     gain_ff   <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Front: term forming and sector classification.
   svsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .push      (push),
      .push_item (push_item),
      .q_full    (q_full)
   );

   // Queue between classification and timing.
   svsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   // Back: vector times, compare sums and clamping.
   svsd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_item      (pop_item),
      .q_empty       (q_empty),
      .pop           (pop),
      .active_period (period_ff),
      .time_gain     (gain_ff),
      .rsp_ch        (rsp_ch)
   );

endmodule

`default_nettype wire

>>> hdl/svsd_checker.sv
`default_nettype none
`include "svpwm_sector_and_duty_defines.svh"

module svsd_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic [svsd_pkg::TICK_W-1:0]     compare_u,
   input  wire logic [svsd_pkg::TICK_W-1:0]     compare_v,
   input  wire logic [svsd_pkg::TICK_W-1:0]     compare_w,
   input  wire logic [svsd_pkg::SECTOR_W-1:0]   sector_number
);

   logic [3*svsd_pkg::TICK_W+svsd_pkg::SECTOR_W-1:0] rsp_payload;
   logic                                             stalled;
   logic                                             no_sector;
   logic                                             cmp_zero;

   // Result fields and the conditions that the properties look at.
   assign rsp_payload = {compare_u, compare_v, compare_w, sector_number};
   assign stalled     = rsp_valid && !rsp_ready;
   assign no_sector   = rsp_valid && (sector_number == 3'd0);
   assign cmp_zero    = (compare_u == '0) && (compare_v == '0) && (compare_w == '0);

   // A held result beat keeps its contents.
   `SVSD_ASSERT_NEXT(a_rsp_hold, stalled, rsp_valid && $stable(rsp_payload), "held beat changed")

   // Only sectors 0 to 6 exist.
   `SVSD_ASSERT_IMPL(a_sector_range, rsp_valid, sector_number <= 3'd6, "sector out of range")

   // A vector with no sector drives all compares to zero.
   `SVSD_ASSERT_IMPL(a_no_sector_zero, no_sector, cmp_zero, "nonzero compare without sector")

   // Reset empties the pipeline.
   `SVSD_ASSERT_ALWAYS_NEXT(a_reset_empty, reset, !rsp_valid, "result valid after reset")

endmodule

bind svpwm_sector_and_duty svsd_checker u_svsd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .compare_u     (rsp_ch.compare_u),
   .compare_v     (rsp_ch.compare_v),
   .compare_w     (rsp_ch.compare_w),
   .sector_number (rsp_ch.sector_number)
);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import svsd_pkg::*;

   localparam int unsigned LATENCY_CYCLES  = 5;
   localparam int unsigned SETTLE_CYCLES   = LATENCY_CYCLES + 3;
   localparam int unsigned WATCHDOG_LIMIT  = 400;
   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned PHASE_VECTORS   = 180;
   localparam int unsigned REPORT_LIMIT    = 10;
   localparam int unsigned RESET_DIRECTED  = 6;
   localparam longint      SQRT3_HALF      = 56756;

   // Indexes of the three voltage terms and of the three phases.
   localparam int T_U1 = 0;
   localparam int T_U2 = 1;
   localparam int T_U3 = 2;
   localparam int PH_U = 0;
   localparam int PH_V = 1;
   localparam int PH_W = 2;

   // Sector from the negative flags {u3, u2, u1}; both all-clear and all-set have none.
   localparam logic [2:0] SECTOR_NONE = 3'd0;
   localparam logic [2:0] SECTOR_BY_SIGNS [8] =
      '{3'd0, 3'd5, 3'd3, 3'd4, 3'd1, 3'd6, 3'd2, 3'd0};

   // Per sector: the two active terms and which phase gets which share of the period.
   localparam int TERM_A  [7] = '{T_U1, T_U2, T_U2, T_U1, T_U1, T_U3, T_U3};
   localparam int TERM_B  [7] = '{T_U1, T_U1, T_U3, T_U3, T_U2, T_U2, T_U1};
   localparam int PH_ALL  [7] = '{PH_U, PH_U, PH_V, PH_V, PH_W, PH_W, PH_U};
   localparam int PH_MID  [7] = '{PH_U, PH_V, PH_U, PH_W, PH_V, PH_U, PH_W};
   localparam int PH_NONE [7] = '{PH_U, PH_W, PH_W, PH_U, PH_U, PH_V, PH_V};

   // Directed vectors: axis extremes, corners, one per sector, sector borders, tiny values.
   localparam int DIRECTED_COUNT = 21;
   localparam logic signed [15:0] DIR_ALPHA [DIRECTED_COUNT] = '{
      0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768,
      866, 0, -866, -866, 0, 866, 8192, -8192, 8192, 1, 0, -1};
   localparam logic signed [15:0] DIR_BETA [DIRECTED_COUNT] = '{
      0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767,
      500, 1000, 500, -500, -1000, -500, 14189, 14189, -14189, 0, -1, 1};
   localparam logic signed [15:0] EDGE_VALUES [5] = '{-32768, -1, 0, 1, 32767};

   typedef struct packed {
      logic signed [VOLT_W-1:0] alpha;
      logic signed [VOLT_W-1:0] beta;
   } vector_type;

   typedef struct packed {
      logic [TICK_W-1:0]   u;
      logic [TICK_W-1:0]   v;
      logic [TICK_W-1:0]   w;
      logic [SECTOR_W-1:0] sector;
   } compare_type;

   logic clock;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   svsd_req_if req_bus ();
   svsd_rsp_if rsp_bus ();

   svpwm_sector_and_duty u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   vector_type  pending_vectors[$];
   compare_type expected_compares[$];
   logic [15:0] cfg_period = '0;
   logic [31:0] cfg_gain = '0;
   int unsigned error_count = 0;
   int unsigned send_gap = 0;
   int unsigned recv_stall = 0;
   int unsigned quiet_cycles = 0;
   bit          send_calm = 1'b0;
   bit          recv_calm = 1'b0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Active vector time in Q16 ticks: |u| * gain, dropping 16 fraction bits.
   function automatic longint vector_ticks(longint term, logic [31:0] gain);
      longint unsigned mag;
      mag = (term < 0) ? -term : term;
      return longint'((mag * {32'd0, gain}) >> 16);
   endfunction

   // Q17 compare to whole ticks, clamped to 0..period.
   function automatic logic [15:0] clamp_ticks(longint q17, logic [15:0] period);
      longint t;
      if (q17 < 0)
         return '0;
      t = q17 >>> 17;
      if (t > longint'(period))
         t = longint'(period);
      return t[15:0];
   endfunction

   // Phase compares and sector for one voltage vector under the given settings.
   function automatic compare_type predict_compares(logic signed [15:0] alpha,
                                                    logic signed [15:0] beta,
                                                    logic [15:0] period, logic [31:0] gain);
      longint      a, b, ta, tb, ts16, twice_zero;
      longint      term [3];
      logic [2:0]  neg;
      logic [2:0]  sec;
      logic [15:0] cmp [3];
      compare_type res;
      a = alpha;
      b = beta;
      term[T_U1] = b * 65536;
      term[T_U2] = a * SQRT3_HALF - b * 32768;
      term[T_U3] = -(a * SQRT3_HALF) - b * 32768;
      neg = {term[T_U3] < 0, term[T_U2] < 0, term[T_U1] < 0};
      sec = SECTOR_BY_SIGNS[neg];
      cmp[PH_U] = '0;
      cmp[PH_V] = '0;
      cmp[PH_W] = '0;
      if (sec != SECTOR_NONE) begin
         ta = vector_ticks(term[TERM_A[sec]], gain);
         tb = vector_ticks(term[TERM_B[sec]], gain);
         ts16 = longint'(period) * 65536;
         twice_zero = ts16 - ta - tb;
         cmp[PH_ALL[sec]]  = clamp_ticks(twice_zero, period);
         cmp[PH_MID[sec]]  = clamp_ticks(2 * ts16 - 2 * tb - twice_zero, period);
         cmp[PH_NONE[sec]] = clamp_ticks(2 * ts16 - twice_zero, period);
      end
      res.u = cmp[PH_U];
      res.v = cmp[PH_V];
      res.w = cmp[PH_W];
      res.sector = sec;
      return res;
   endfunction

   task automatic record_error(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   task automatic add_vector(logic signed [15:0] alpha, logic signed [15:0] beta);
      vector_type vec;
      vec.alpha = alpha;
      vec.beta = beta;
      pending_vectors.push_back(vec);
   endtask

   // Mostly full-range vectors, plus small ones, extremes and exact sector borders.
   task automatic add_random_vector();
      logic signed [15:0] a, b;
      int unsigned        mode, k;
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
         a = 16'($urandom);
         b = 16'($urandom);
      end else if (mode <= 7) begin
         a = 16'($urandom_range(0, 4000) - 2000);
         b = 16'($urandom_range(0, 4000) - 2000);
      end else if (mode == 8) begin
         a = EDGE_VALUES[$urandom_range(0, 4)];
         b = EDGE_VALUES[$urandom_range(0, 4)];
      end else begin
         k = $urandom_range(1, 2);
         a = $urandom_range(0, 1) ? 16'(8192 * k) : 16'(-8192 * k);
         b = $urandom_range(0, 1) ? 16'(14189 * k) : 16'(-14189 * k);
      end
      add_vector(a, b);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == REG_ACTIVE_PERIOD)
         cfg_period = value[15:0];
      else
         cfg_gain = value;
   endtask

   task automatic program_settings(logic [15:0] period, logic [31:0] gain);
      write_register(REG_ACTIVE_PERIOD, {16'd0, period});
      write_register(REG_TIME_GAIN, gain);
      @(negedge clock);
   endtask

   // Hold off until every queued vector has been sent and every result has come back.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_vectors.size() != 0 || expected_compares.size() != 0 || req_bus.valid);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Driver: one vector beat at a time, with a random gap after each accepted beat.
   always @(posedge clock) begin : drive_vectors
      vector_type next_vec;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid)
            expected_compares.push_back(predict_compares(req_bus.v_alpha, req_bus.v_beta,
                                                         cfg_period, cfg_gain));
         if (send_gap != 0) begin
            req_bus.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_vectors.size() != 0) begin
            next_vec = pending_vectors.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.v_alpha <= next_vec.alpha;
            req_bus.v_beta <= next_vec.beta;
            if ($urandom_range(0, 39) == 0)
               send_calm <= !send_calm;
            send_gap <= send_calm ? 0 : $urandom_range(0, 5);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Monitor: check each result beat against the oldest prediction, then stall at random.
   always @(posedge clock) begin : check_results
      compare_type got, want;
      int unsigned stall;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall <= 0;
      end else begin
         stall = recv_stall;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.u = rsp_bus.compare_u;
            got.v = rsp_bus.compare_v;
            got.w = rsp_bus.compare_w;
            got.sector = rsp_bus.sector_number;
            if (expected_compares.size() == 0) begin
               record_error($sformatf("unexpected result beat u=%0d v=%0d w=%0d sector=%0d",
                                      got.u, got.v, got.w, got.sector));
            end else begin
               want = expected_compares.pop_front();
               if (got.u !== want.u || got.v !== want.v || got.w !== want.w ||
                   got.sector !== want.sector)
                  record_error($sformatf(
                     "expected u=%0d v=%0d w=%0d sector=%0d, got u=%0d v=%0d w=%0d sector=%0d",
                     want.u, want.v, want.w, want.sector,
                     got.u, got.v, got.w, got.sector));
            end
            if ($urandom_range(0, 39) == 0)
               recv_calm <= !recv_calm;
            stall = recv_calm ? 0 : $urandom_range(0, 5);
         end else if (stall != 0) begin
            stall = stall - 1;
         end
         rsp_bus.ready <= (stall == 0);
         recv_stall <= stall;
      end
   end

   // Watchdog: give up when neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run_phases
      logic [15:0] period;
      logic [31:0] gain;
      req_bus.valid = 1'b0;
      req_bus.v_alpha = '0;
      req_bus.v_beta = '0;
      rsp_bus.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Settings straight out of reset: every compare must be zero.
      for (int i = 0; i < RESET_DIRECTED; i++)
         add_vector(DIR_ALPHA[i], DIR_BETA[i]);
      wait_drained();

      // Directed vectors under a moderate, mostly linear setting.
      program_settings(16'd1000, 32'd2300);
      for (int i = 0; i < DIRECTED_COUNT; i++)
         add_vector(DIR_ALPHA[i], DIR_BETA[i]);
      wait_drained();

      // Random phases, each under its own period and gain.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               period = 16'hFFFF;
               gain = 32'hFFFF_FFFF;
            end
            1: begin
               period = 16'd0;
               gain = $urandom;
            end
            2: begin
               period = 16'hFFFF;
               gain = 32'd131070;
            end
            3: begin
               period = 16'($urandom_range(1, 65535));
               gain = $urandom_range(0, 15);
            end
            4: begin
               period = 16'($urandom_range(1, 65535));
               gain = $urandom;
            end
            default: begin
               period = 16'($urandom_range(1, 65535));
               gain = period * $urandom_range(1, 4) + $urandom_range(0, period);
            end
         endcase
         program_settings(period, gain);
         repeat (PHASE_VECTORS) add_random_vector();
         wait_drained();
      end

      if (expected_compares.size() != 0)
         record_error($sformatf("%0d results never arrived", expected_compares.size()));
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/svsd_pkg.sv
hdl/svsd_ifs.sv
hdl/svsd_front.sv
hdl/svsd_queue.sv
hdl/svsd_back.sv
hdl/svpwm_sector_and_duty.sv
hdl/svsd_checker.sv
tb/testbench.sv
